/* hw/rtl/esdw_pkg.sv */
// ----------------------------------------------------------------------------
// esdw_pkg: shared types and constants for the eight-sector direction weights
// Holds the arctangent table, the coordinate width and the record that moves
// down the CORDIC cell chain.
// ----------------------------------------------------------------------------
package esdw_pkg;

  // Coordinate width inside the chain: 32-bit input, one extra bit for the
  // initial half-turn, and headroom for the CORDIC gain of about 1.65 * sqrt(2).
  localparam int unsigned CoordW = 35;

  // Angles are binary angles: 2^32 is one full turn.
  localparam int unsigned AngW = 32;

  // Number of compass directions and where the sector number sits in an angle.
  localparam int unsigned NumDirs    = 8;
  localparam int unsigned SectorW    = 3;
  localparam int unsigned SectorLsb  = AngW - SectorW;

  // Half a turn, used when the vector is flipped into the right half plane.
  localparam logic [AngW-1:0] HalfTurn = 32'h8000_0000;

  // Magnitude check: 1/K in Q0.16 and the width of x that still matters
  // against a 16-bit dead zone.
  localparam int unsigned    DeadZoneW = 16;
  localparam int unsigned    MagInW    = 18;
  localparam int unsigned    GainW     = 16;
  localparam int unsigned    ProdW     = MagInW + GainW;
  localparam int unsigned    MagW      = ProdW - 16;
  localparam logic [GainW-1:0] InvGainQ16 = 16'd39797;

  // atan(2^-i) as a binary angle, truncated.
  localparam int unsigned AtanEntries = 24;
  localparam logic [AngW-1:0] AtanTurns [AtanEntries] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

  // One transaction as it moves from cell to cell.
  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [AngW-1:0]          ang;
  } cordic_rec_t;

endpackage

/* hw/rtl/esdw_cordic_cell.sv */
// ----------------------------------------------------------------------------
// esdw_cordic_cell: one CORDIC vectoring micro-rotation
// Rotates the vector toward the x axis by atan(2^-STAGE_IDX), accumulates the
// angle and hands the result to the next cell on every clock.
// ----------------------------------------------------------------------------
module esdw_cordic_cell import esdw_pkg::*; #(
  parameter int unsigned STAGE_IDX = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_rec_t cell_i,
  output cordic_rec_t cell_o
);

  logic signed [CoordW-1:0] x_s, y_s, xs_s, ys_s;
  logic                     rot_cw;
  cordic_rec_t              cell_d, cell_q;

  // Shifted copies of the incoming coordinates.
  assign x_s  = cell_i.x;
  assign y_s  = cell_i.y;
  assign xs_s = x_s >>> STAGE_IDX;
  assign ys_s = y_s >>> STAGE_IDX;

  // A vector on or above the axis turns clockwise, otherwise counter-clockwise.
  assign rot_cw = ~y_s[CoordW-1];

  always_comb begin
    cell_d       = cell_i;
    if (rot_cw) begin
      cell_d.x   = x_s + ys_s;
      cell_d.y   = y_s - xs_s;
      cell_d.ang = cell_i.ang + AtanTurns[STAGE_IDX];
    end else begin
      cell_d.x   = x_s - ys_s;
      cell_d.y   = y_s + xs_s;
      cell_d.ang = cell_i.ang - AtanTurns[STAGE_IDX];
    end
  end

  // Register handed to the next cell; reset clears the whole record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* hw/rtl/esdw_weight_unit.sv */
// ----------------------------------------------------------------------------
// esdw_weight_unit: magnitude check and sector weights
// Scales the final x by 1/K, compares it with the dead zone and spreads the
// angle over the two neighboring compass directions.
// ----------------------------------------------------------------------------
module esdw_weight_unit import esdw_pkg::*; #(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  cordic_rec_t                              rec_i,
  input  logic [DeadZoneW-1:0]                     dead_zone_i,
  output logic                                     done_o,
  output logic [NumDirs-1:0][WEIGHT_FRAC_BITS:0]   weights_o
);

  localparam logic [WEIGHT_FRAC_BITS:0] WeightOne     = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
  localparam logic [WEIGHT_FRAC_BITS:0] WeightUniform = WeightOne >> 3;

  logic [ProdW-1:0]        prod;
  logic                    big;
  logic                    mag_valid_q;
  logic                    mag_zero_q, mag_big_q;
  logic [MagW-1:0]         mag_q;
  logic [AngW-1:0]         mag_ang_q;
  logic                    uniform;
  logic [SectorW-1:0]      sector, sector_next;
  logic [WEIGHT_FRAC_BITS-1:0] frac;
  logic [NumDirs-1:0][WEIGHT_FRAC_BITS:0] weights_d, weights_q;
  logic                    done_q;

  // Any bit of x above the low bits already puts the magnitude past the
  // largest dead zone, so only the low bits go through the multiplier.
  assign big  = |rec_i.x[CoordW-2:MagInW];
  assign prod = ProdW'(rec_i.x[MagInW-1:0]) * ProdW'(InvGainQ16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_valid_q <= 1'b0;
    end else begin
      mag_valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_zero_q <= rec_i.zero;
    mag_big_q  <= big;
    mag_q      <= prod[ProdW-1:16];
    mag_ang_q  <= rec_i.ang;
  end

  // Uniform weights for a zero vector or a magnitude inside the dead zone.
  assign uniform = mag_zero_q | (~mag_big_q & (mag_q < MagW'(dead_zone_i)));

  // Sector number and the fraction of the way to the next direction.
  assign sector      = mag_ang_q[AngW-1:SectorLsb];
  assign sector_next = sector + SectorW'(1);
  assign frac        = mag_ang_q[SectorLsb-1 -: WEIGHT_FRAC_BITS];

  always_comb begin
    for (int i = 0; i < NumDirs; i++) begin
      weights_d[i] = uniform ? WeightUniform : '0;
    end
    if (!uniform) begin
      weights_d[sector]      = WeightOne - {1'b0, frac};
      weights_d[sector_next] = {1'b0, frac};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mag_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    weights_q <= weights_d;
  end

  assign done_o    = done_q;
  assign weights_o = weights_q;

endmodule

/* hw/rtl/eight_sector_direction_weights.sv */
// ----------------------------------------------------------------------------
// eight_sector_direction_weights: compass weights from an error vector
// A chain of CORDIC vectoring cells finds the angle and magnitude of a Q16.16
// error vector; eight Q1.16 weights for directions 45 degrees apart follow.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  ----------------------------------
//  command   in         start, busy            error_x_i, error_y_i
//  result    out        done_o (strobe)        weight_east_o .. weight_southeast_o
//  config    in         cfg_we_i               cfg_wdata_i (dead zone)
//
// A new transaction is taken every cycle; busy never rises.
// The path runs through one launch register, one cell per CORDIC stage,
// then the magnitude multiply register and the weight register.
// Reset clears the launch register, the cell chain, the valid bits of the
// weight unit and the dead zone register.
// The result is shown for one cycle with done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
module eight_sector_direction_weights import esdw_pkg::*; #(
  parameter int unsigned CORDIC_STAGES    = 16,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          error_x_i,
  input  logic signed [31:0]          error_y_i,
  input  logic                        cfg_we_i,
  input  logic [DeadZoneW-1:0]        cfg_wdata_i,
  output logic                        done_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_east_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_northeast_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_north_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_northwest_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_west_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_southwest_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_south_o,
  output logic [WEIGHT_FRAC_BITS:0]   weight_southeast_o
);

  localparam int unsigned Latency = CORDIC_STAGES + 3;
  localparam logic [WEIGHT_FRAC_BITS:0] WeightOne = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  logic [DeadZoneW-1:0]     dead_zone_q;
  logic signed [CoordW-1:0] x_ext, y_ext;
  cordic_rec_t              launch_d;
  cordic_rec_t              chain [CORDIC_STAGES+1];
  logic [NumDirs-1:0][WEIGHT_FRAC_BITS:0] weights;
  logic [WEIGHT_FRAC_BITS+3:0] weight_sum;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Dead zone register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= '0;
    end else if (cfg_we_i) begin
      dead_zone_q <= cfg_wdata_i;
    end
  end

  // Flip a vector in the left half plane by half a turn before the chain.
  assign x_ext = CoordW'(error_x_i);
  assign y_ext = CoordW'(error_y_i);

  always_comb begin
    launch_d.valid = start & ~busy;
    launch_d.zero  = (error_x_i == '0) && (error_y_i == '0);
    if (error_x_i[31]) begin
      launch_d.x   = -x_ext;
      launch_d.y   = -y_ext;
      launch_d.ang = HalfTurn;
    end else begin
      launch_d.x   = x_ext;
      launch_d.y   = y_ext;
      launch_d.ang = '0;
    end
  end

  // Launch register at the head of the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= launch_d;
    end
  end

  // Row of CORDIC cells, one per stage.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    esdw_cordic_cell #(
      .STAGE_IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // Magnitude check and weight spreading.
  esdw_weight_unit #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_weight_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (chain[CORDIC_STAGES]),
    .dead_zone_i (dead_zone_q),
    .done_o      (done_o),
    .weights_o   (weights)
  );

  assign weight_east_o      = weights[0];
  assign weight_northeast_o = weights[1];
  assign weight_north_o     = weights[2];
  assign weight_northwest_o = weights[3];
  assign weight_west_o      = weights[4];
  assign weight_southwest_o = weights[5];
  assign weight_south_o     = weights[6];
  assign weight_southeast_o = weights[7];

  // Sum of all weights, for the checks below.
  always_comb begin
    weight_sum = '0;
    for (int i = 0; i < NumDirs; i++) begin
      weight_sum = weight_sum + (WEIGHT_FRAC_BITS+4)'(weights[i]);
    end
  end

  // Every accepted transaction produces a result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("accepted transaction produced no result");

  // No result without an accepted transaction the latency earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without a matching transaction");

  // The weights always add up to exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (weight_sum == (WEIGHT_FRAC_BITS+4)'(WeightOne)))
    else $error("weights do not sum to one");

  // A zero vector gives uniform weights; the check looks at the east output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && error_x_i == '0 && error_y_i == '0)
      |-> ##Latency (weight_east_o == (WeightOne >> 3)))
    else $error("zero vector did not give uniform weights");

endmodule

/* tb/eight_sector_direction_weights_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_sector_direction_weights_test: self-checking bench for the compass weights
// Drives error vectors through the command port and keeps its own CORDIC
// vectoring predictor with a copy of the dead zone. Every result strobe is
// compared per direction against the oldest predicted weight set.
// ----------------------------------------------------------------------------
module eight_sector_direction_weights_test;
  import esdw_pkg::*;

  localparam int unsigned Stages         = 16;
  localparam int unsigned WeightFracBits = 16;
  localparam int unsigned Latency        = Stages + 3;
  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned ItemsPerPhase  = 220;

  localparam logic [31:0]  HalfTurnAng = 32'h8000_0000;
  localparam logic [63:0]  InvGainQ0p16 = 64'd39797;
  localparam logic [WeightFracBits:0] FullWeight    = {1'b1, {WeightFracBits{1'b0}}};
  localparam logic [WeightFracBits:0] UniformWeight = FullWeight >> 3;

  localparam logic signed [31:0] MostNegative = 32'sh8000_0000;
  localparam logic signed [31:0] MostPositive = 32'sh7fff_ffff;
  localparam logic signed [31:0] UnitQ16      = 32'sd65536;
  localparam logic signed [31:0] DiagQ16      = 32'sd46341;

  // Per-stage rotation angles as binary angles (2^32 is one turn).
  localparam logic [31:0] StepAngles [Stages] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860
  };

  typedef logic [NumDirs-1:0][WeightFracBits:0] weight_vec_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic signed [31:0]         error_x;
  logic signed [31:0]         error_y;
  logic                       cfg_we_i;
  logic [DeadZoneW-1:0]       cfg_wdata_i;
  logic                       done_o;
  logic [WeightFracBits:0]    weight_east;
  logic [WeightFracBits:0]    weight_northeast;
  logic [WeightFracBits:0]    weight_north;
  logic [WeightFracBits:0]    weight_northwest;
  logic [WeightFracBits:0]    weight_west;
  logic [WeightFracBits:0]    weight_southwest;
  logic [WeightFracBits:0]    weight_south;
  logic [WeightFracBits:0]    weight_southeast;

  logic [DeadZoneW-1:0] dead_zone_copy;
  weight_vec_t          weights_pending [$];
  int unsigned          mismatch_count;
  int unsigned          stall_cycles;
  bit                   steady_stream;

  string dir_names [NumDirs] = '{
    "weight_east", "weight_northeast", "weight_north", "weight_northwest",
    "weight_west", "weight_southwest", "weight_south", "weight_southeast"
  };

  eight_sector_direction_weights #(
    .CORDIC_STAGES    (Stages),
    .WEIGHT_FRAC_BITS (WeightFracBits)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .error_x_i          (error_x),
    .error_y_i          (error_y),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .weight_east_o      (weight_east),
    .weight_northeast_o (weight_northeast),
    .weight_north_o     (weight_north),
    .weight_northwest_o (weight_northwest),
    .weight_west_o      (weight_west),
    .weight_southwest_o (weight_southwest),
    .weight_south_o     (weight_south),
    .weight_southeast_o (weight_southeast)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Compass weights of one error vector: CORDIC vectoring on 64-bit
  // coordinates, magnitude check against the dead zone, then the split
  // of the angle between the two neighboring directions.
  function automatic weight_vec_t predict_weights(input logic signed [31:0] ex,
                                                  input logic signed [31:0] ey,
                                                  input logic [DeadZoneW-1:0] dz);
    logic signed [63:0]      px;
    logic signed [63:0]      py;
    logic signed [63:0]      shx;
    logic signed [63:0]      shy;
    logic [31:0]             ang;
    logic [63:0]             mag;
    logic [2:0]              sector;
    logic [WeightFracBits:0] frac;
    weight_vec_t             w;
    w   = '0;
    ang = '0;
    px  = {{32{ex[31]}}, ex};
    py  = {{32{ey[31]}}, ey};
    if (px == 0 && py == 0) begin
      for (int d = 0; d < NumDirs; d++) w[d] = UniformWeight;
      return w;
    end
    // Fold the left half plane over by half a turn.
    if (px[63]) begin
      px  = -px;
      py  = -py;
      ang = HalfTurnAng;
    end
    for (int i = 0; i < Stages; i++) begin
      shx = px >>> i;
      shy = py >>> i;
      if (!py[63]) begin
        px  = px + shy;
        py  = py - shx;
        ang = ang + StepAngles[i];
      end else begin
        px  = px - shy;
        py  = py + shx;
        ang = ang - StepAngles[i];
      end
    end
    mag = ($unsigned(px) * InvGainQ0p16) >> 16;
    if (mag < {48'd0, dz}) begin
      for (int d = 0; d < NumDirs; d++) w[d] = UniformWeight;
      return w;
    end
    sector = ang[31:29];
    frac   = {1'b0, ang[28:29-WeightFracBits]};
    w[sector]        = FullWeight - frac;
    w[sector + 3'd1] = frac;
    return w;
  endfunction

  // Record the expected weights of every accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      weights_pending.push_back(predict_weights(error_x, error_y, dead_zone_copy));
    end
  end

  // Compare each result strobe with the oldest expectation.
  always @(posedge clk_i) begin
    weight_vec_t seen;
    weight_vec_t want;
    if (rst_ni && done_o) begin
      seen = {weight_southeast, weight_south, weight_southwest, weight_west,
              weight_northwest, weight_north, weight_northeast, weight_east};
      if (weights_pending.size() == 0) begin
        $error("weights: result strobe with no transaction pending");
        mismatch_count++;
      end else begin
        want = weights_pending.pop_front();
        for (int d = 0; d < NumDirs; d++) begin
          if (seen[d] !== want[d]) begin
            $error("%s: expected %0d, actual %0d", dir_names[d], want[d], seen[d]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Idle cycles before the next command: none in a steady stream, else mostly
  // none, sometimes a few, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_stream || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one error vector and hold it until the block takes it.
  task automatic send_vector(input logic signed [31:0] ex, input logic signed [31:0] ey);
    int unsigned idle;
    idle = pick_gap();
    if (idle != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (idle - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start   <= 1'b1;
    error_x <= ex;
    error_y <= ey;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop sending and wait until every pending result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (weights_pending.size() != 0) @(posedge clk_i);
  endtask

  // Dead zone writes happen only with the pipeline empty.
  task automatic set_dead_zone(input logic [DeadZoneW-1:0] dz);
    drain_results();
    @(negedge clk_i);
    cfg_we_i       <= 1'b1;
    cfg_wdata_i    <= dz;
    dead_zone_copy = dz;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Zero vector, the corners of the input range and points on the axes.
  task automatic test_extremes();
    send_vector(0, 0);
    send_vector(MostNegative, MostNegative);
    send_vector(MostPositive, MostPositive);
    send_vector(MostNegative, MostPositive);
    send_vector(MostPositive, MostNegative);
    send_vector(MostNegative, 0);
    send_vector(0, MostNegative);
    send_vector(-1, 0);
  endtask

  // Unit vectors along all eight compass directions.
  task automatic test_compass_points();
    send_vector(UnitQ16, 0);
    send_vector(DiagQ16, DiagQ16);
    send_vector(0, UnitQ16);
    send_vector(-DiagQ16, DiagQ16);
    send_vector(-UnitQ16, 0);
    send_vector(-DiagQ16, -DiagQ16);
    send_vector(0, -UnitQ16);
    send_vector(DiagQ16, -DiagQ16);
  endtask

  // Magnitudes right around the largest and the smallest nonzero dead zone.
  task automatic test_dead_zone();
    set_dead_zone(16'hffff);
    send_vector(UnitQ16, 0);
    send_vector(UnitQ16 - 1, 0);
    send_vector(0, -(UnitQ16 + 1));
    send_vector(-32'sd80000, 32'sd100);
    send_vector(DiagQ16, -DiagQ16);
    set_dead_zone(16'd1);
    send_vector(1, 0);
    send_vector(0, -2);
    send_vector(-3, 1);
  endtask

  // One random error vector, drawn from a mix of value classes.
  task automatic send_random_vector();
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] m;
    m = $urandom;
    case ($urandom_range(0, 5))
      0, 1: begin
        ex = $urandom;
        ey = $urandom;
      end
      2: begin
        ex = $urandom_range(0, 262143) - 131072;
        ey = $urandom_range(0, 262143) - 131072;
      end
      3: begin
        // Vectors on an axis or a diagonal.
        case ($urandom_range(0, 3))
          0: begin ex = m; ey = 0; end
          1: begin ex = 0; ey = m; end
          2: begin ex = m; ey = m; end
          default: begin ex = m; ey = -m; end
        endcase
      end
      4: begin
        // Magnitudes near the current dead zone.
        ex = $urandom_range(0, 2 * dead_zone_copy + 2);
        ey = $urandom_range(0, dead_zone_copy / 2 + 1);
        if ($urandom_range(0, 1)) ex = -ex;
        if ($urandom_range(0, 1)) ey = -ey;
        if ($urandom_range(0, 1)) begin
          m  = ex;
          ex = ey;
          ey = m;
        end
      end
      default: begin
        ex = $urandom_range(0, 6) - 3;
        ey = $urandom_range(0, 6) - 3;
      end
    endcase
    send_vector(ex, ey);
  endtask

  // Random vectors under several dead zone settings, one with no idle cycles.
  task automatic test_random_vectors();
    logic [DeadZoneW-1:0] zones [5];
    zones = '{16'd0, 16'hffff, DeadZoneW'($urandom), 16'd1, DeadZoneW'($urandom)};
    for (int p = 0; p < 5; p++) begin
      set_dead_zone(zones[p]);
      steady_stream = (p == 2);
      repeat (ItemsPerPhase) send_random_vector();
    end
    steady_stream = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    error_x        = '0;
    error_y        = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    dead_zone_copy = '0;
    mismatch_count = 0;
    steady_stream  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_compass_points();
    test_dead_zone();
    test_random_vectors();

    drain_results();
    repeat (Latency + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
